// ===== design/dgma_pkg.sv =====
package dgma_pkg;

    // Fixed field and datapath widths.
    localparam int ACC_W       = 48;              // Q24.24 accumulator
    localparam int SAMPLE_W    = 16;              // Q4.12 sample
    localparam int PROD_W      = 2 * SAMPLE_W;    // exact Q8.24 product
    localparam int DAMP_W      = 16;              // Q0.16 damping
    localparam int MUL_W       = ACC_W + DAMP_W;  // mean times damping
    localparam int DIMREG_W    = 7;
    localparam int FIELD_IDX_W = 6;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [ACC_W-1:0]    ONE_Q24         = ACC_W'(1) << 24;
    localparam logic [DIMREG_W-1:0] DIMENSION_RESET = 7'd64;
    localparam logic [DAMP_W-1:0]   DAMPING_RESET   = 16'd655;

    // Register select, taken from paddr bit 2.
    localparam logic REG_DIMENSION = 1'b0;
    localparam logic REG_DAMPING   = 1'b1;

    typedef enum logic [1:0] {
        ACT_PUSH     = 2'd0,
        ACT_FINALIZE = 2'd1,
        ACT_READ     = 2'd2,
        ACT_CLEAR    = 2'd3
    } action_t;

    // Start requests for the iterative divide and multiply unit.
    typedef struct packed {
        logic start_div;
        logic start_mul;
    } dgma_op_t;

endpackage

// ===== design/dgma_mac.sv =====
module dgma_mac
    import dgma_pkg::*;
(
    input  logic                       clk,
    input  logic                       mul_en,
    input  logic signed [SAMPLE_W-1:0] mul_a,
    input  logic signed [SAMPLE_W-1:0] mul_b,
    input  logic                       use_lam,
    input  logic        [ACC_W-1:0]    lam,
    input  logic        [ACC_W-1:0]    acc_in,
    output logic        [ACC_W-1:0]    acc_out
);

    logic signed [PROD_W-1:0] prod_reg;
    logic        [ACC_W-1:0]  addend;
    logic        [ACC_W:0]    sum_wide;

    // The product is registered before it reaches the adder.
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    always_comb
    begin
        if (use_lam)
        begin
            addend = lam;
        end
        else
        begin
            addend = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        sum_wide = {acc_in[ACC_W-1], acc_in} + {addend[ACC_W-1], addend};
        // Overflow shows as a disagreement of the two top bits.
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            acc_out = sum_wide[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                      : {1'b0, {(ACC_W - 1){1'b1}}};
        end
        else
        begin
            acc_out = sum_wide[ACC_W-1:0];
        end
    end

endmodule

// ===== design/dgma_divmul.sv =====
module dgma_divmul
    import dgma_pkg::*;
#(
    parameter int DIVIDEND_W = 53,
    parameter int DIVISOR_W  = 7
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dgma_op_t              op,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    input  logic [ACC_W-1:0]      mcand,
    input  logic [DAMP_W-1:0]     mplier,
    output logic                  done,
    output logic [ACC_W-1:0]      result
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_MUL
    } mode_t;

    mode_t                  mode_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DIVIDEND_W-1:0]  quo_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [DIVISOR_W-1:0]   divisor_reg;
    logic [MUL_W-1:0]       acc_reg;
    logic [MUL_W-1:0]       mcand_reg;
    logic [DAMP_W-1:0]      mplier_reg;
    logic                   done_reg;
    logic [ACC_W-1:0]       result_reg;

    logic [DIVISOR_W:0]     rem_shift;
    logic [DIVISOR_W:0]     rem_sub;
    logic                   fits;
    logic [DIVISOR_W-1:0]   rem_next;
    logic [DIVIDEND_W-1:0]  quo_next;
    logic [MUL_W-1:0]       acc_next;

    // One restoring division step or one shift-add step per cycle.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_sub   = rem_shift - {1'b0, divisor_reg};
        fits      = (rem_shift >= {1'b0, divisor_reg});
        rem_next  = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
        acc_next  = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= U_IDLE;
            cnt_reg     <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
            acc_reg     <= '0;
            mcand_reg   <= '0;
            mplier_reg  <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (mode_reg)
                U_IDLE:
                begin
                    if (op.start_div)
                    begin
                        quo_reg     <= dividend;
                        rem_reg     <= '0;
                        divisor_reg <= divisor;
                        cnt_reg     <= CNT_W'(DIVIDEND_W);
                        mode_reg    <= U_DIV;
                    end
                    else if (op.start_mul)
                    begin
                        acc_reg    <= '0;
                        mcand_reg  <= MUL_W'(mcand);
                        mplier_reg <= mplier;
                        cnt_reg    <= CNT_W'(DAMP_W);
                        mode_reg   <= U_MUL;
                    end
                end
                U_DIV:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        result_reg <= quo_next[ACC_W-1:0];
                        done_reg   <= 1'b1;
                        mode_reg   <= U_IDLE;
                    end
                end
                U_MUL:
                begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= {mcand_reg[MUL_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[DAMP_W-1:1]};
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        result_reg <= acc_next[MUL_W-1:DAMP_W];
                        done_reg   <= 1'b1;
                        mode_reg   <= U_IDLE;
                    end
                end
                default:
                begin
                    mode_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/damped_gram_matrix_accumulator_core.sv =====
// A push at vector position p updates the mirrored entry pair for each earlier position, then
// the diagonal; a read waits while the output is stalled. A finalize divides bit by bit.
// A clear zeroes all 2**(2*ceil(log2(MAX_DIM))) store entries, one per cycle (4096 at 64).
// Throughput: one request at a time; the store's single read and write port sets the pace.
// Reset: rst_n is asynchronous, active low; after it the same clearing pass runs before
// the first request is taken, while configuration writes are taken at once.
module damped_gram_matrix_accumulator_core
    import dgma_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample[15:0], row_index[21:16],
                                              // col_index[27:22], zero[31:28]
    input  logic [1:0]             s_tuser,   // action[1:0]
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // entry_value[47:0]
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // Index widths. The store is addressed as {row, col}, so a dimension that is not a
    // power of two simply leaves some store words unused.
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int CMP_W       = (DIM_W > DIMREG_W) ? DIM_W : DIMREG_W;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int SUM_W       = ACC_W + IDX_W;
    localparam int DIVIDEND_W  = SUM_W - 1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PVRD,
        S_PMUL,
        S_PACC1,
        S_PACC2,
        S_PDIAG,
        S_PDWR,
        S_FSUMRD,
        S_FSUMACC,
        S_FCHECK,
        S_FDIV,
        S_FMUL,
        S_FADDRD,
        S_FADDWR,
        S_ROUT
    } state_t;

    // Control and payload registers.
    state_t                      state_reg,     state_next;
    logic [ADDR_W-1:0]           clr_reg,       clr_next;
    logic [IDX_W-1:0]            pos_reg,       pos_next;
    logic [IDX_W-1:0]            p_reg,         p_next;
    logic [IDX_W-1:0]            j_reg,         j_next;
    logic signed [SAMPLE_W-1:0]  x_reg,         x_next;
    logic                        finalized_reg, finalized_next;
    logic [SUM_W-1:0]            sum_reg,       sum_next;
    logic [ACC_W-1:0]            lam_reg,       lam_next;
    logic                        in_range_reg,  in_range_next;
    logic                        m_tvalid_reg,  m_tvalid_next;
    logic [OUT_TDATA_W-1:0]      m_tdata_reg,   m_tdata_next;
    logic [DIMREG_W-1:0]         dimension_reg, dimension_next;
    logic [DAMP_W-1:0]           damping_reg,   damping_next;

    // Memories.
    logic [ACC_W-1:0]            store_mem [STORE_DEPTH];
    logic [ACC_W-1:0]            store_rdata_reg;
    logic signed [SAMPLE_W-1:0]  vbuf_mem [MAX_DIM];
    logic signed [SAMPLE_W-1:0]  vbuf_rdata_reg;

    // Store and buffer port controls.
    logic                        store_we;
    logic [ADDR_W-1:0]           store_waddr;
    logic [ACC_W-1:0]            store_wdata;
    logic                        store_re;
    logic [ADDR_W-1:0]           store_raddr;
    logic                        vbuf_we;
    logic                        vbuf_re;

    // Shared arithmetic.
    logic                        mul_en;
    logic signed [SAMPLE_W-1:0]  mul_a;
    logic signed [SAMPLE_W-1:0]  mul_b;
    logic                        use_lam;
    logic [ACC_W-1:0]            mac_out;
    dgma_op_t                    unit_op;
    logic [ACC_W-1:0]            unit_mcand;
    logic                        unit_done;
    logic [ACC_W-1:0]            unit_result;

    // Decoded request and derived values.
    logic                        accept;
    logic                        cfg_we;
    action_t                     in_action;
    logic signed [SAMPLE_W-1:0]  in_sample;
    logic [CMP_W-1:0]            row_c;
    logic [CMP_W-1:0]            col_c;
    logic                        in_range;
    logic [CMP_W-1:0]            dim_c;
    logic [CMP_W-1:0]            dim_eff;
    logic [IDX_W-1:0]            start_pos;
    logic [CMP_W-1:0]            p_inc;
    logic [CMP_W-1:0]            j_inc;
    logic                        sum_pos;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite && pready;

    assign in_action = action_t'(s_tuser);
    assign in_sample = signed'(s_tdata[SAMPLE_W-1:0]);
    assign row_c     = CMP_W'(s_tdata[SAMPLE_W +: FIELD_IDX_W]);
    assign col_c     = CMP_W'(s_tdata[SAMPLE_W + FIELD_IDX_W +: FIELD_IDX_W]);

    // A dimension of zero acts as one, and one above MAX_DIM acts as MAX_DIM.
    always_comb
    begin
        dim_c = CMP_W'(dimension_reg);
        if (dim_c == '0)
        begin
            dim_eff = CMP_W'(1);
        end
        else if (dim_c > CMP_W'(MAX_DIM))
        begin
            dim_eff = CMP_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = dim_c;
        end
    end

    assign in_range  = (row_c < dim_eff) && (col_c < dim_eff);
    // When the dimension shrank to or below the saved position, a new vector starts at zero.
    assign start_pos = (CMP_W'(pos_reg) >= dim_eff) ? '0 : pos_reg;
    assign p_inc     = CMP_W'(p_reg) + CMP_W'(1);
    assign j_inc     = CMP_W'(j_reg) + CMP_W'(1);
    assign sum_pos   = !sum_reg[SUM_W-1] && (sum_reg != '0);

    // Configuration read-back.
    always_comb
    begin
        case (paddr[2])
            REG_DIMENSION: prdata = APB_DATA_W'(dimension_reg);
            REG_DAMPING:   prdata = APB_DATA_W'(damping_reg);
            default:       prdata = '0;
        endcase
    end

    // Port usage of the store, the vector buffer and the shared units per state.
    always_comb
    begin
        store_we    = 1'b0;
        store_waddr = '0;
        store_wdata = mac_out;
        store_re    = 1'b0;
        store_raddr = '0;
        vbuf_we     = 1'b0;
        vbuf_re     = 1'b0;
        mul_en      = 1'b0;
        mul_a       = x_reg;
        mul_b       = x_reg;
        use_lam     = 1'b0;
        unit_op     = '0;
        unit_mcand  = ONE_Q24;
        case (state_reg)
            S_CLEAR:
            begin
                store_we    = 1'b1;
                store_waddr = clr_reg;
                store_wdata = '0;
            end
            S_IDLE:
            begin
                if (accept && (in_action == ACT_READ))
                begin
                    store_re    = 1'b1;
                    store_raddr = {row_c[IDX_W-1:0], col_c[IDX_W-1:0]};
                end
                if (accept && (in_action == ACT_PUSH) && !finalized_reg)
                begin
                    vbuf_we = 1'b1;
                end
            end
            S_PVRD:
            begin
                vbuf_re = 1'b1;
            end
            S_PMUL:
            begin
                mul_en      = 1'b1;
                mul_b       = vbuf_rdata_reg;
                store_re    = 1'b1;
                store_raddr = {p_reg, j_reg};
            end
            S_PACC1:
            begin
                store_we    = 1'b1;
                store_waddr = {p_reg, j_reg};
                store_re    = 1'b1;
                store_raddr = {j_reg, p_reg};
            end
            S_PACC2:
            begin
                store_we    = 1'b1;
                store_waddr = {j_reg, p_reg};
            end
            S_PDIAG:
            begin
                mul_en      = 1'b1;
                store_re    = 1'b1;
                store_raddr = {p_reg, p_reg};
            end
            S_PDWR:
            begin
                store_we    = 1'b1;
                store_waddr = {p_reg, p_reg};
            end
            S_FSUMRD, S_FADDRD:
            begin
                store_re    = 1'b1;
                store_raddr = {j_reg, j_reg};
            end
            S_FCHECK:
            begin
                // A sum that is not positive gives a mean that is not positive.
                unit_op.start_div = sum_pos;
                unit_op.start_mul = !sum_pos;
            end
            S_FDIV:
            begin
                unit_op.start_mul = unit_done;
                unit_mcand        = (unit_result == '0) ? ONE_Q24 : unit_result;
            end
            S_FADDWR:
            begin
                use_lam     = 1'b1;
                store_we    = 1'b1;
                store_waddr = {j_reg, j_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        p_next         = p_reg;
        j_next         = j_reg;
        x_next         = x_reg;
        finalized_next = finalized_reg;
        sum_next       = sum_reg;
        lam_next       = lam_reg;
        in_range_next  = in_range_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        dimension_next = dimension_reg;
        damping_next   = damping_reg;

        if (cfg_we)
        begin
            case (paddr[2])
                REG_DIMENSION: dimension_next = pwdata[DIMREG_W-1:0];
                REG_DAMPING:   damping_next   = pwdata[DAMP_W-1:0];
                default:       dimension_next = dimension_reg;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_action)
                        ACT_PUSH:
                        begin
                            // Pushes after a finalize are dropped until a clear.
                            if (!finalized_reg)
                            begin
                                x_next     = in_sample;
                                p_next     = start_pos;
                                j_next     = '0;
                                state_next = (start_pos == '0) ? S_PDIAG : S_PVRD;
                            end
                        end
                        ACT_FINALIZE:
                        begin
                            if (!finalized_reg)
                            begin
                                sum_next   = '0;
                                j_next     = '0;
                                state_next = S_FSUMRD;
                            end
                        end
                        ACT_READ:
                        begin
                            in_range_next = in_range;
                            state_next    = S_ROUT;
                        end
                        ACT_CLEAR:
                        begin
                            pos_next       = '0;
                            finalized_next = 1'b0;
                            clr_next       = '0;
                            state_next     = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PVRD:
            begin
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                state_next = S_PACC1;
            end
            S_PACC1:
            begin
                state_next = S_PACC2;
            end
            S_PACC2:
            begin
                j_next     = j_inc[IDX_W-1:0];
                state_next = (j_inc == CMP_W'(p_reg)) ? S_PDIAG : S_PVRD;
            end
            S_PDIAG:
            begin
                state_next = S_PDWR;
            end
            S_PDWR:
            begin
                // The position wraps to zero after the last element of a vector.
                pos_next   = (p_inc >= dim_eff) ? '0 : p_inc[IDX_W-1:0];
                state_next = S_IDLE;
            end
            S_FSUMRD:
            begin
                state_next = S_FSUMACC;
            end
            S_FSUMACC:
            begin
                sum_next   = sum_reg + {{IDX_W{store_rdata_reg[ACC_W-1]}}, store_rdata_reg};
                j_next     = j_inc[IDX_W-1:0];
                state_next = (j_inc == dim_eff) ? S_FCHECK : S_FSUMRD;
            end
            S_FCHECK:
            begin
                state_next = sum_pos ? S_FDIV : S_FMUL;
            end
            S_FDIV:
            begin
                if (unit_done)
                begin
                    state_next = S_FMUL;
                end
            end
            S_FMUL:
            begin
                if (unit_done)
                begin
                    lam_next   = unit_result;
                    j_next     = '0;
                    state_next = S_FADDRD;
                end
            end
            S_FADDRD:
            begin
                state_next = S_FADDWR;
            end
            S_FADDWR:
            begin
                j_next = j_inc[IDX_W-1:0];
                if (j_inc == dim_eff)
                begin
                    finalized_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_FADDRD;
                end
            end
            S_ROUT:
            begin
                // The read waits here while the output register is still occupied.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = in_range_reg ? store_rdata_reg : '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            p_reg         <= '0;
            j_reg         <= '0;
            x_reg         <= '0;
            finalized_reg <= 1'b0;
            sum_reg       <= '0;
            lam_reg       <= '0;
            in_range_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            dimension_reg <= DIMENSION_RESET;
            damping_reg   <= DAMPING_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            p_reg         <= p_next;
            j_reg         <= j_next;
            x_reg         <= x_next;
            finalized_reg <= finalized_next;
            sum_reg       <= sum_next;
            lam_reg       <= lam_next;
            in_range_reg  <= in_range_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            dimension_reg <= dimension_next;
            damping_reg   <= damping_next;
        end
    end

    // Gram store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        if (store_re)
        begin
            store_rdata_reg <= store_mem[store_raddr];
        end
    end

    // Vector buffer: written at the pushed position, read at the partner index.
    always_ff @(posedge clk)
    begin
        if (vbuf_we)
        begin
            vbuf_mem[start_pos] <= in_sample;
        end
        if (vbuf_re)
        begin
            vbuf_rdata_reg <= vbuf_mem[j_reg];
        end
    end

    // Shared multiplier and saturating adder.
    dgma_mac u_mac
    (
        .clk     (clk),
        .mul_en  (mul_en),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .use_lam (use_lam),
        .lam     (lam_reg),
        .acc_in  (store_rdata_reg),
        .acc_out (mac_out)
    );

    // Bit-serial divider for the mean and shift-add multiplier for the damping term.
    dgma_divmul
    #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (CMP_W)
    )
    u_divmul
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (unit_op),
        .dividend (sum_reg[DIVIDEND_W-1:0]),
        .divisor  (dim_eff),
        .mcand    (unit_mcand),
        .mplier   (damping_reg),
        .done     (unit_done),
        .result   (unit_result)
    );

    // An accepted push that is not dropped keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_action == ACT_PUSH) && !finalized_reg) |=> !s_tready)
        else $error("push request did not start an update sequence");

    // The finalized flag is set only at the end of the diagonal damping pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(finalized_reg) |-> $past(state_reg == S_FADDWR))
        else $error("finalized flag set outside the damping pass");

    // The divide and multiply unit reports completion only while it is awaited.
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> ((state_reg == S_FDIV) || (state_reg == S_FMUL)))
        else $error("arithmetic unit finished while not awaited");

    // A new result appears only as the last step of a read request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_ROUT))
        else $error("result presented without a read request");

endmodule
